// ===== hw/rtl/square_tiling_count_matrix_power_macros.svh =====
// ----------------------------------------------------------------------------
// Square tiling count: assertion macros
// Short forms for the concurrent checks used by the block.
// ----------------------------------------------------------------------------
`ifndef SQUARE_TILING_COUNT_MATRIX_POWER_MACROS_SVH
`define SQUARE_TILING_COUNT_MATRIX_POWER_MACROS_SVH

// Condition must never hold outside reset.
`define STCMP_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define STCMP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define STCMP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/stcmp_pkg.sv =====
// ----------------------------------------------------------------------------
// Square tiling count: package
// Sizes, modulus constants, shared types and the transfer-step function.
// ----------------------------------------------------------------------------
package stcmp_pkg;

  localparam int MAX_COLS = 7;
  localparam int IDX_W    = MAX_COLS;
  localparam int DIM      = 1 << MAX_COLS;
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int VAL_W    = 24;
  localparam int NBANK    = 3;

  localparam logic [VAL_W-1:0] MOD_VAL   = 24'd10000007;
  // floor(2^48 / MOD_VAL)
  localparam logic [24:0]      BARRETT_R = 25'd28147477;

  typedef logic [1:0] bank_sel_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  data;
  } bank_wr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr0;
    logic [ADDR_W-1:0] addr1;
  } bank_rd_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic valid;
    logic busy;
  } mm_status_t;

  // 1 when nxt is made of pairs of adjacent columns within cols, all free in prev.
  function automatic logic step_ok(logic [IDX_W-1:0] prev, logic [IDX_W-1:0] nxt,
                                   logic [2:0] cols);
    logic           ok;
    logic           skip;
    logic [IDX_W:0] ext;
    ok   = ((prev & nxt) == '0);
    skip = 1'b0;
    ext  = {1'b0, nxt};
    for (int c = 0; c < IDX_W; c++) begin
      if (skip) begin
        skip = 1'b0;
      end else if (ext[c]) begin
        if ((c + 1) >= int'(cols) || !ext[c+1]) ok = 1'b0;
        skip = 1'b1;
      end
    end
    return ok;
  endfunction

endpackage

// ===== hw/rtl/stcmp_mat_bank.sv =====
// ----------------------------------------------------------------------------
// Square tiling count: matrix bank
// One matrix store, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module stcmp_mat_bank (
  input  logic                         clk,
  input  stcmp_pkg::bank_wr_t          wr,
  input  stcmp_pkg::bank_rd_t          rd,
  output logic [stcmp_pkg::VAL_W-1:0]  rd0_data,
  output logic [stcmp_pkg::VAL_W-1:0]  rd1_data
);
  import stcmp_pkg::*;

  logic [VAL_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (wr.we) mem[wr.addr] <= wr.data;
    rd0_data <= mem[rd.addr0];
    rd1_data <= mem[rd.addr1];
  end

endmodule

// ===== hw/rtl/stcmp_cell.sv =====
// ----------------------------------------------------------------------------
// Square tiling count: accumulator cell
// One column accumulator of the row chain; shifts toward the head.
// ----------------------------------------------------------------------------
module stcmp_cell (
  input  logic                         clk,
  input  stcmp_pkg::cell_ctrl_t        ctrl,
  input  logic                         is_tail,
  input  logic [stcmp_pkg::VAL_W-1:0]  next_in,
  input  logic [stcmp_pkg::VAL_W-1:0]  tail_in,
  output logic [stcmp_pkg::VAL_W-1:0]  acc
);
  import stcmp_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc <= '0;
    end else if (ctrl.shift) begin
      acc <= is_tail ? tail_in : next_in;
    end
  end

endmodule

// ===== hw/rtl/stcmp_modmul.sv =====
// ----------------------------------------------------------------------------
// Square tiling count: modular multiplier
// Four-stage a*b mod 10000007 using Barrett reduction.
// ----------------------------------------------------------------------------
module stcmp_modmul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_vld,
  input  logic [stcmp_pkg::VAL_W-1:0]  a,
  input  logic [stcmp_pkg::VAL_W-1:0]  b,
  output stcmp_pkg::mm_status_t        status,
  output logic [stcmp_pkg::VAL_W-1:0]  t
);
  import stcmp_pkg::*;

  localparam logic [25:0] MOD2 = 26'(2 * 10000007);
  localparam logic [25:0] MOD1 = 26'(MOD_VAL);

  logic        v1, v2, v3, v4;
  logic [47:0] p;
  logic [49:0] m1;
  logic [25:0] p2, p3, m2;
  logic [25:0] r, r1, r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4} <= '0;
    end else begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_comb begin
    r  = p3 - m2;
    r1 = (r >= MOD2) ? r - MOD2 : r;
    r2 = (r1 >= MOD1) ? r1 - MOD1 : r1;
  end

  always_ff @(posedge clk) begin
    p  <= 48'(a) * 48'(b);
    m1 <= 50'(p[46:22]) * 50'(BARRETT_R);
    p2 <= p[25:0];
    m2 <= 26'(48'(m1[49:26]) * 48'(MOD_VAL));
    p3 <= p2;
    t  <= r2[VAL_W-1:0];
  end

  assign status.valid = v4;
  assign status.busy  = v1 | v2 | v3 | v4;

endmodule

// ===== hw/rtl/square_tiling_count_matrix_power.sv =====
// ----------------------------------------------------------------------------
// Square tiling count: top level
// Counts tilings of a board by 1x1 and 2x2 squares, modulo 10000007.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall carries board_rows and board_cols; the
//   block stalls while it works on one item. Output channel out_valid /
//   out_stall carries tiling_count and width_error from an output register,
//   so a new item is taken while a finished result waits.
// Flow: a board with at most one row or one column, or too many columns,
//   goes from idle straight to the done state. Otherwise, with n = 2^cols,
//   setup fills n*n entries of each of two banks, and there are up to two
//   matrix products per exponent bit of board_rows. All products share the
//   one multiply-reduce pipeline, which takes one multiply-accumulate per
//   cycle while a row is multiplied.
// Rows of each product collect in a chain of column cells that rotate past
//   the accumulator at its head, then drain to the destination bank.
// Reset: clears the controller and handshakes; matrix banks need no clearing
//   as every entry read is written during setup of the same item.
// Stall: a held result keeps out_valid and payload stable; a finished item
//   waits in its last state until the output register is free.
// ----------------------------------------------------------------------------
`include "square_tiling_count_matrix_power_macros.svh"

module square_tiling_count_matrix_power (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [30:0]                  board_rows,
  input  logic [2:0]                   board_cols,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [stcmp_pkg::VAL_W-1:0]  tiling_count,
  output logic                         width_error
);
  import stcmp_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_INIT  = 9'b000000010,
    S_NEXT  = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_FLUSH = 9'b000010000,
    S_WRB   = 9'b000100000,
    S_READ  = 9'b001000000,
    S_READ2 = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t            state;
  logic [30:0]       exp_left;
  logic [2:0]        cols;
  logic [IDX_W-1:0]  nm1;
  logic [IDX_W-1:0]  i, j, k;
  logic              odd_done;
  logic              prod_sq;
  bank_sel_t         acc_sel, pow_sel, free_sel;
  logic [VAL_W-1:0]  res_count;
  logic              res_err;
  logic              v0;

  logic              accept;
  logic              out_free;
  bank_sel_t         a_sel;
  bank_rd_t          rd;
  bank_wr_t          wr [NBANK];
  logic [VAL_W-1:0]  rd0_q [NBANK];
  logic [VAL_W-1:0]  rd1_q [NBANK];
  mm_status_t        mm_st;
  logic [VAL_W-1:0]  mm_t;
  cell_ctrl_t        cctrl;
  logic [VAL_W-1:0]  cell_acc [DIM];
  logic [VAL_W-1:0]  tail_val;
  logic [VAL_W:0]    sum;
  logic              init_t;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign a_sel    = prod_sq ? pow_sel : acc_sel;

  // Read addresses: row i of a, row j of b; A(0,0) at the end.
  always_comb begin
    rd.addr0 = (state == S_MUL) ? {i, j} : '0;
    rd.addr1 = {j, k};
  end

  assign init_t = step_ok(i, j, cols);

  // Write ports: setup fills identity and transfer matrix, drain fills dst.
  always_comb begin
    for (int b = 0; b < NBANK; b++) begin
      wr[b].addr = {i, (state == S_WRB) ? k : j};
      if (state == S_INIT) begin
        wr[b].we   = (bank_sel_t'(b) == acc_sel) || (bank_sel_t'(b) == pow_sel);
        wr[b].data = (bank_sel_t'(b) == acc_sel) ? VAL_W'(i == j) : VAL_W'(init_t);
      end else begin
        wr[b].we   = (state == S_WRB) && (bank_sel_t'(b) == free_sel);
        wr[b].data = cell_acc[0];
      end
    end
  end

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    stcmp_mat_bank u_bank (
      .clk      (clk),
      .wr       (wr[b]),
      .rd       (rd),
      .rd0_data (rd0_q[b]),
      .rd1_data (rd1_q[b])
    );
  end

  stcmp_modmul u_mm (
    .clk    (clk),
    .rst    (rst),
    .in_vld (v0),
    .a      (rd0_q[a_sel]),
    .b      (rd1_q[pow_sel]),
    .status (mm_st),
    .t      (mm_t)
  );

  // Head accumulate, reduce once, reinsert at the tail; drain feeds zeros in.
  always_comb begin
    sum = {1'b0, cell_acc[0]} + {1'b0, mm_t};
    if (state == S_WRB) begin
      tail_val = '0;
    end else if (sum >= {1'b0, MOD_VAL}) begin
      tail_val = VAL_W'(sum - {1'b0, MOD_VAL});
    end else begin
      tail_val = sum[VAL_W-1:0];
    end
    cctrl.clr   = (state == S_NEXT);
    cctrl.shift = mm_st.valid || (state == S_WRB);
  end

  for (genvar c = 0; c < DIM; c++) begin : g_cell
    stcmp_cell u_cell (
      .clk     (clk),
      .ctrl    (cctrl),
      .is_tail (IDX_W'(c) == nm1),
      .next_in ((c == DIM - 1) ? '0 : cell_acc[(c + 1) % DIM]),
      .tail_in (tail_val),
      .acc     (cell_acc[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      v0        <= 1'b0;
      out_valid <= 1'b0;
      acc_sel   <= 2'd0;
      pow_sel   <= 2'd1;
      free_sel  <= 2'd2;
      odd_done  <= 1'b0;
      prod_sq   <= 1'b0;
      exp_left  <= '0;
    end else begin
      v0 <= (state == S_MUL);
      // Load the output register when free, drop valid once taken.
      if ((state == S_DONE) && out_free) out_valid <= 1'b1;
      else if (!out_stall)               out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cols <= board_cols;
            nm1  <= IDX_W'((1 << board_cols) - 1);
            i    <= '0;
            j    <= '0;
            odd_done <= 1'b0;
            exp_left <= board_rows;
            if (32'(board_cols) > MAX_COLS) begin
              res_count <= '0;
              res_err   <= 1'b1;
              state     <= S_DONE;
            end else if (board_rows <= 31'd1 || board_cols <= 3'd1) begin
              res_count <= VAL_W'(1);
              res_err   <= 1'b0;
              state     <= S_DONE;
            end else begin
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          if (j == nm1) begin
            j <= '0;
            i <= i + 1'b1;
            if (i == nm1) state <= S_NEXT;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_NEXT: begin
          // One exponent step: multiply on an odd bit, then square if higher bits remain.
          i <= '0;
          j <= '0;
          k <= '0;
          if (exp_left == '0) begin
            state <= S_READ;
          end else if (exp_left[0] && !odd_done) begin
            odd_done <= 1'b1;
            prod_sq  <= 1'b0;
            state    <= S_MUL;
          end else begin
            odd_done <= 1'b0;
            exp_left <= exp_left >> 1;
            prod_sq  <= 1'b1;
            state    <= ((exp_left >> 1) != '0) ? S_MUL : S_READ;
          end
        end
        S_MUL: begin
          if (k == nm1) begin
            k <= '0;
            j <= j + 1'b1;
            if (j == nm1) state <= S_FLUSH;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_FLUSH: begin
          if (!v0 && !mm_st.busy) begin
            k     <= '0;
            state <= S_WRB;
          end
        end
        S_WRB: begin
          if (k == nm1) begin
            k <= '0;
            j <= '0;
            i <= i + 1'b1;
            if (i == nm1) begin
              // Hand the fresh bank over and free the old one.
              free_sel <= prod_sq ? pow_sel : acc_sel;
              if (prod_sq) pow_sel <= free_sel;
              else         acc_sel <= free_sel;
              state <= S_NEXT;
            end else begin
              state <= S_MUL;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        S_READ: begin
          state <= S_READ2;
        end
        S_READ2: begin
          res_count <= rd0_q[acc_sel];
          res_err   <= 1'b0;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            tiling_count <= res_count;
            width_error  <= res_err;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `STCMP_ASSERT_NEVER(a_bank_distinct, clk, rst, (acc_sel == pow_sel) || (acc_sel == free_sel) || (pow_sel == free_sel), "bank roles overlap")
  `STCMP_ASSERT_IMPL(a_acc_in_product, clk, rst, mm_st.valid, (state == S_MUL) || (state == S_FLUSH), "product term outside a product")
  `STCMP_ASSERT_NEXT(a_accept_busy, clk, rst, accept, state != S_IDLE, "accepted item left no work")

endmodule
